/* design/aba_pkg.sv */
package aba_pkg;

	// Fixed field widths of the request and result records.
	localparam int FUNC_W     = 2;
	localparam int REQ_W      = 32;
	localparam int ALOG_W     = 4;
	localparam int ADDR_W     = 48;
	localparam int SIDX_W     = 4;
	localparam int STATUS_W   = 2;
	localparam int STAT_W     = 33;
	localparam int CAP_W      = 33;
	localparam int OVF_W      = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 48;

	// Defaults for the top-level parameters.
	localparam int COUNT_BITS_DEF     = 33;
	localparam int MAX_ALIGN_LOG2_DEF = 12;

	// Register reset values.
	localparam logic [CAP_W-1:0]  CAPACITY_RST = CAP_W'(1048576);
	localparam logic [ADDR_W-1:0] BASE_RST     = '0;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE     = 1'd1;

	// Operation codes.
	localparam logic [FUNC_W-1:0] FUNC_ALLOC       = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_RELEASE     = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FRAME_RESET = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_READ_STAT   = 2'd3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_RELEASE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RESET_BUSY  = 2'd3;

	// Statistic selectors.
	localparam logic [SIDX_W-1:0] STAT_CLAIMED      = 4'd0;
	localparam logic [SIDX_W-1:0] STAT_PAYLOAD      = 4'd1;
	localparam logic [SIDX_W-1:0] STAT_PADDING      = 4'd2;
	localparam logic [SIDX_W-1:0] STAT_CLAIMS       = 4'd3;
	localparam logic [SIDX_W-1:0] STAT_LAST_CLAIMED = 4'd4;
	localparam logic [SIDX_W-1:0] STAT_LAST_PAYLOAD = 4'd5;
	localparam logic [SIDX_W-1:0] STAT_LAST_PADDING = 4'd6;
	localparam logic [SIDX_W-1:0] STAT_LAST_CLAIMS  = 4'd7;
	localparam logic [SIDX_W-1:0] STAT_PEAK         = 4'd8;
	localparam logic [SIDX_W-1:0] STAT_OUTSTANDING  = 4'd9;
	localparam logic [SIDX_W-1:0] STAT_OVERFLOWS    = 4'd10;
	localparam logic [SIDX_W-1:0] STAT_FAIL_SIZE    = 4'd11;
	localparam logic [SIDX_W-1:0] STAT_FAIL_ALIGN   = 4'd12;
	localparam logic [SIDX_W-1:0] STAT_FAIL_CLAIMED = 4'd13;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [REQ_W-1:0]  request_size;
		logic [ALOG_W-1:0] align_log2;
		logic [ADDR_W-1:0] release_address;
		logic [SIDX_W-1:0] stat_index;
	} aba_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   grant_address;
		logic [STAT_W-1:0]   stat_value;
	} aba_rsp_t;

	typedef struct packed {
		logic [CAP_W-1:0]  capacity;
		logic [ADDR_W-1:0] base;
	} aba_cfg_t;

endpackage

/* design/aba_cfg_regs.sv */
module aba_cfg_regs
	import aba_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output aba_cfg_t              cfg
);

	logic [CAP_W-1:0]  capacity_q;
	logic [ADDR_W-1:0] base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RST;
			base_q     <= BASE_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_CAPACITY: begin
					capacity_q <= cfg_wdata[CAP_W-1:0];
				end
				REG_BASE: begin
					base_q <= cfg_wdata[ADDR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.capacity = capacity_q;
	assign cfg.base     = base_q;

endmodule

/* design/aba_engine.sv */
module aba_engine
	import aba_pkg::*;
#(
	parameter int COUNT_BITS     = COUNT_BITS_DEF,
	parameter int MAX_ALIGN_LOG2 = MAX_ALIGN_LOG2_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  aba_cfg_t cfg,
	input  logic     fire,
	input  aba_req_t req,
	output aba_rsp_t rsp
);

	localparam int XW    = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 2;
	localparam int AW    = ((COUNT_BITS > ADDR_W) ? COUNT_BITS : ADDR_W) + 1;
	localparam int PAD_W = (MAX_ALIGN_LOG2 > 0) ? MAX_ALIGN_LOG2 : 1;
	localparam logic [4:0]            MAX_A   = 5'(MAX_ALIGN_LOG2);
	localparam logic [COUNT_BITS-1:0] CMAX    = '1;
	localparam logic [XW-1:0]         CMAX_X  = {{(XW-COUNT_BITS){1'b0}}, CMAX};
	localparam logic [XW-1:0]         ONE_X   = XW'(1);
	localparam logic [OVF_W-1:0]      OVF_MAX = '1;

	logic [COUNT_BITS-1:0] claimed_q, payload_q, padding_q, claims_q, peak_q, outst_q;
	logic [COUNT_BITS-1:0] last_q [4];
	logic [COUNT_BITS-1:0] fail_size_q, fail_align_q, fail_claimed_q;
	logic [OVF_W-1:0]      ovf_q;

	logic [4:0]            align_a;
	logic [PAD_W-1:0]      amask, pad;
	logic [AW-1:0]         addr_x, grant_x;
	logic [XW-1:0]         claimed_x, size_x, req_x, pad_x, end_x, cap_x, lim_x;
	logic [XW-1:0]         pay_sum, pad_sum, align_x, stat_x;
	logic                  fits, owned;
	logic [ADDR_W-1:0]     rel_diff;
	logic [COUNT_BITS-1:0] claimed_nxt, pay_nxt, pad_nxt, claims_nxt, outst_inc;
	logic [OVF_W-1:0]      ovf_nxt;

	// Allocation arithmetic: align the absolute bump address, then check
	// that the padded claim still ends inside the usable capacity.
	always_comb begin
		align_a   = ({1'b0, req.align_log2} > MAX_A) ? MAX_A : {1'b0, req.align_log2};
		amask     = ~({PAD_W{1'b1}} << align_a);
		addr_x    = {{(AW-ADDR_W){1'b0}}, cfg.base}
		          + {{(AW-COUNT_BITS){1'b0}}, claimed_q};
		pad       = (PAD_W'(0) - addr_x[PAD_W-1:0]) & amask;
		grant_x   = addr_x + {{(AW-PAD_W){1'b0}}, pad};
		claimed_x = {{(XW-COUNT_BITS){1'b0}}, claimed_q};
		req_x     = {{(XW-REQ_W){1'b0}}, req.request_size};
		size_x    = (req.request_size == '0) ? ONE_X : req_x;
		pad_x     = {{(XW-PAD_W){1'b0}}, pad};
		end_x     = claimed_x + pad_x + size_x;
		cap_x     = {{(XW-CAP_W){1'b0}}, cfg.capacity};
		lim_x     = (cap_x < CMAX_X) ? cap_x : CMAX_X;
		fits      = (end_x <= lim_x);
		align_x   = ONE_X << align_a;

		claimed_nxt = end_x[COUNT_BITS-1:0];
		pay_sum     = {{(XW-COUNT_BITS){1'b0}}, payload_q} + req_x;
		pad_sum     = {{(XW-COUNT_BITS){1'b0}}, padding_q} + pad_x;
		pay_nxt     = (pay_sum > CMAX_X) ? CMAX : pay_sum[COUNT_BITS-1:0];
		pad_nxt     = (pad_sum > CMAX_X) ? CMAX : pad_sum[COUNT_BITS-1:0];
		claims_nxt  = (claims_q == CMAX) ? CMAX : claims_q + 1'b1;
		outst_inc   = (outst_q == CMAX) ? CMAX : outst_q + 1'b1;
		ovf_nxt     = (ovf_q == OVF_MAX) ? OVF_MAX : ovf_q + 1'b1;

		// Ownership uses the full capacity, not the counter-limited one.
		rel_diff = req.release_address - cfg.base;
		owned    = (req.release_address >= cfg.base)
		        && (rel_diff < {{(ADDR_W-CAP_W){1'b0}}, cfg.capacity});
	end

	// Statistic selection.
	always_comb begin
		unique case (req.stat_index) inside
			STAT_CLAIMED:      stat_x = claimed_x;
			STAT_PAYLOAD:      stat_x = {{(XW-COUNT_BITS){1'b0}}, payload_q};
			STAT_PADDING:      stat_x = {{(XW-COUNT_BITS){1'b0}}, padding_q};
			STAT_CLAIMS:       stat_x = {{(XW-COUNT_BITS){1'b0}}, claims_q};
			STAT_LAST_CLAIMED, STAT_LAST_PAYLOAD, STAT_LAST_PADDING, STAT_LAST_CLAIMS:
			                   stat_x = {{(XW-COUNT_BITS){1'b0}}, last_q[req.stat_index[1:0]]};
			STAT_PEAK:         stat_x = {{(XW-COUNT_BITS){1'b0}}, peak_q};
			STAT_OUTSTANDING:  stat_x = {{(XW-COUNT_BITS){1'b0}}, outst_q};
			STAT_OVERFLOWS:    stat_x = {{(XW-OVF_W){1'b0}}, ovf_q};
			STAT_FAIL_SIZE:    stat_x = {{(XW-COUNT_BITS){1'b0}}, fail_size_q};
			STAT_FAIL_ALIGN:   stat_x = {{(XW-COUNT_BITS){1'b0}}, fail_align_q};
			STAT_FAIL_CLAIMED: stat_x = {{(XW-COUNT_BITS){1'b0}}, fail_claimed_q};
			default:           stat_x = '0;
		endcase
	end

	// Result of the request now in the input register.
	always_comb begin
		rsp = '0;
		unique case (req.func)
			FUNC_ALLOC: begin
				if (fits) begin
					rsp.grant_address = grant_x[ADDR_W-1:0];
				end else begin
					rsp.status = ST_FULL;
				end
			end
			FUNC_RELEASE: begin
				if (!owned || outst_q == '0) begin
					rsp.status = ST_BAD_RELEASE;
				end
			end
			FUNC_FRAME_RESET: begin
				if (outst_q != '0) begin
					rsp.status = ST_RESET_BUSY;
				end
			end
			FUNC_READ_STAT: begin
				rsp.stat_value = stat_x[STAT_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			claimed_q      <= '0;
			payload_q      <= '0;
			padding_q      <= '0;
			claims_q       <= '0;
			peak_q         <= '0;
			outst_q        <= '0;
			ovf_q          <= '0;
			fail_size_q    <= '0;
			fail_align_q   <= '0;
			fail_claimed_q <= '0;
			for (int i = 0; i < 4; i++) begin
				last_q[i] <= '0;
			end
		end else if (fire) begin
			unique case (req.func)
				FUNC_ALLOC: begin
					if (fits) begin
						claimed_q <= claimed_nxt;
						payload_q <= pay_nxt;
						padding_q <= pad_nxt;
						claims_q  <= claims_nxt;
						outst_q   <= outst_inc;
						if (claimed_nxt > peak_q) begin
							peak_q <= claimed_nxt;
						end
					end else begin
						ovf_q          <= ovf_nxt;
						fail_size_q    <= req_x[COUNT_BITS-1:0];
						fail_align_q   <= align_x[COUNT_BITS-1:0];
						fail_claimed_q <= claimed_q;
					end
				end
				FUNC_RELEASE: begin
					if (owned && outst_q != '0) begin
						outst_q <= outst_q - 1'b1;
					end
				end
				FUNC_FRAME_RESET: begin
					if (outst_q == '0) begin
						last_q[0] <= claimed_q;
						last_q[1] <= payload_q;
						last_q[2] <= padding_q;
						last_q[3] <= claims_q;
						claimed_q <= '0;
						payload_q <= '0;
						padding_q <= '0;
						claims_q  <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	a_peak_covers_claimed: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= claimed_q)
		else $error("peak offset fell below the claimed offset");

	a_frame_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req.func == FUNC_FRAME_RESET && rsp.status == ST_OK
		|=> claimed_q == '0 && claims_q == '0)
		else $error("accepted frame reset did not clear the frame totals");

	a_grant_outstanding: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req.func == FUNC_ALLOC && rsp.status == ST_OK |=> outst_q != '0)
		else $error("granted allocation left nothing outstanding");

endmodule

/* design/aligned_bump_allocator_top.sv */
// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall  aba_req_t: func, size, alignment, address, stat
// rsp       out        rsp_valid/rsp_stall  aba_rsp_t: status, grant address, stat value
// cfg       in         cfg_wr (no wait)     cfg_idx selects capacity or base, cfg_wdata
//
// A request is accepted into the input register and executes from there into the result
// register once that is free or being emptied. One request can be accepted in every cycle
// while the result is not stalled: the claimed-offset register feeds its own update
// through the single align, add and compare path.
// Reset clears all counters and loads the capacity with 1 MiB and the base with zero.
// A stalled result holds the result register; the input register then keeps its
// request and req_stall rises until the result is taken.
module aligned_bump_allocator_top
	import aba_pkg::*;
#(
	parameter int COUNT_BITS     = COUNT_BITS_DEF,
	parameter int MAX_ALIGN_LOG2 = MAX_ALIGN_LOG2_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  aba_req_t              req_data,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output aba_rsp_t              rsp_data,
	input  logic                  cfg_wr,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	aba_cfg_t cfg;
	aba_req_t req_s1;
	aba_rsp_t rsp_s2, rsp_comb;
	logic     vld_s1, vld_s2;
	logic     fire;
	logic     take;

	// The request in the input register executes when the result register is
	// free or is being emptied in this same cycle.
	assign fire      = vld_s1 && !(vld_s2 && rsp_stall);
	assign req_stall = vld_s1 && !fire;
	assign take      = req_valid && !req_stall;

	aba_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	aba_engine #(
		.COUNT_BITS     (COUNT_BITS),
		.MAX_ALIGN_LOG2 (MAX_ALIGN_LOG2)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.req    (req_s1),
		.rsp    (rsp_comb)
	);

	// Valid bits of the input and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (take) begin
				vld_s1 <= 1'b1;
			end else if (fire) begin
				vld_s1 <= 1'b0;
			end
			if (fire) begin
				vld_s2 <= 1'b1;
			end else if (!rsp_stall) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	// Payload registers load only on a handshake, so a stalled result holds.
	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req_data;
		end
		if (fire) begin
			rsp_s2 <= rsp_comb;
		end
	end

	assign rsp_valid = vld_s2;
	assign rsp_data  = rsp_s2;

	a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("input stalled although the result register could advance");

	a_error_result_is_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != ST_OK
		|-> rsp_data.grant_address == '0 && rsp_data.stat_value == '0)
		else $error("refused request carried a grant address or statistic");

endmodule

/* tb/sv/tb_aligned_bump_allocator_top.sv */
`timescale 1ns / 100ps

module tb_aligned_bump_allocator_top;
	import aba_pkg::*;

	// Statistic selectors that the block does not define; they must read as zero.
	localparam logic [SIDX_W-1:0] STAT_UNUSED_LO = 4'd14;
	localparam logic [SIDX_W-1:0] STAT_UNUSED_HI = 4'd15;

	// Saturation limits and masks, all held in 64-bit words.
	localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS_DEF) - 64'd1;
	localparam logic [63:0] OVF_MAX   = (64'd1 << OVF_W) - 64'd1;
	localparam logic [63:0] ADDR_MASK = (64'd1 << ADDR_W) - 64'd1;
	localparam logic [63:0] MIB       = 64'd1048576;

	// Cycles without any handshake or register write before the run is declared hung.
	localparam int unsigned QUIET_LIMIT = 3000;
	// Length of the deliberate receiver hold-off used to back the block up.
	localparam int unsigned LONG_HOLD = 60;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	aba_req_t              req_data = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	aba_rsp_t              rsp_data;
	logic                  cfg_wr = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = REG_CAPACITY;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	aligned_bump_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_wr    (cfg_wr),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Requests waiting to be offered, and responses predicted for accepted requests.
	aba_req_t pending_requests[$];
	aba_rsp_t predicted_rsps[$];

	// Our own view of the two arena registers, updated when they are written.
	logic [CAP_W-1:0]  cap_reg = CAPACITY_RST;
	logic [ADDR_W-1:0] base_reg = BASE_RST;

	// Arena bookkeeping mirrored from the block's documented behavior.
	logic [STAT_W-1:0] claimed = '0;
	logic [STAT_W-1:0] payload_sum = '0;
	logic [STAT_W-1:0] padding_sum = '0;
	logic [STAT_W-1:0] grants_sum = '0;
	logic [STAT_W-1:0] last_frame[4] = '{default: '0};
	logic [STAT_W-1:0] peak = '0;
	logic [STAT_W-1:0] outstanding = '0;
	logic [OVF_W-1:0]  full_refusals = '0;
	logic [STAT_W-1:0] fail_rec[3] = '{default: '0};

	// Traffic shaping controls, written by the sequencing block at falling edges.
	bit steady = 1'b0;
	bit pressure_req = 1'b0;

	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;

	function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
		if (a >= lim || b > lim - a)
			return lim;
		return a + b;
	endfunction

	// Applies one accepted request to the mirrored arena and returns the response
	// the block must produce for it.
	function automatic aba_rsp_t arena_apply(aba_req_t r);
		aba_rsp_t    o;
		logic [63:0] usable, size, amask, addr, pad, rel, base;
		int unsigned a;
		o = '0;
		case (r.func)
		FUNC_ALLOC: begin
			usable = (64'(cap_reg) < COUNT_MAX) ? 64'(cap_reg) : COUNT_MAX;
			size = (r.request_size == '0) ? 64'd1 : 64'(r.request_size);
			a = (r.align_log2 > MAX_ALIGN_LOG2_DEF) ? MAX_ALIGN_LOG2_DEF : r.align_log2;
			amask = (64'd1 << a) - 64'd1;
			addr = 64'(base_reg) + 64'(claimed);
			pad = (64'd0 - addr) & amask;
			if (64'(claimed) > usable || pad > usable - 64'(claimed) ||
					size > usable - 64'(claimed) - pad) begin
				full_refusals = OVF_W'(sat_sum(64'(full_refusals), 64'd1, OVF_MAX));
				fail_rec[0] = STAT_W'(64'(r.request_size) & COUNT_MAX);
				fail_rec[1] = STAT_W'((64'd1 << a) & COUNT_MAX);
				fail_rec[2] = claimed;
				o.status = ST_FULL;
			end else begin
				o.grant_address = ADDR_W'((addr + pad) & ADDR_MASK);
				claimed = STAT_W'(64'(claimed) + pad + size);
				payload_sum = STAT_W'(sat_sum(64'(payload_sum), 64'(r.request_size),
					COUNT_MAX));
				padding_sum = STAT_W'(sat_sum(64'(padding_sum), pad, COUNT_MAX));
				grants_sum = STAT_W'(sat_sum(64'(grants_sum), 64'd1, COUNT_MAX));
				outstanding = STAT_W'(sat_sum(64'(outstanding), 64'd1, COUNT_MAX));
				if (claimed > peak)
					peak = claimed;
			end
		end
		FUNC_RELEASE: begin
			rel = 64'(r.release_address);
			base = 64'(base_reg);
			if (rel < base || rel - base >= 64'(cap_reg) || outstanding == '0)
				o.status = ST_BAD_RELEASE;
			else
				outstanding = outstanding - 1'b1;
		end
		FUNC_FRAME_RESET: begin
			if (outstanding != '0) begin
				o.status = ST_RESET_BUSY;
			end else begin
				last_frame[0] = claimed;
				last_frame[1] = payload_sum;
				last_frame[2] = padding_sum;
				last_frame[3] = grants_sum;
				claimed = '0;
				payload_sum = '0;
				padding_sum = '0;
				grants_sum = '0;
			end
		end
		default: begin
			case (r.stat_index)
			STAT_CLAIMED:      o.stat_value = claimed;
			STAT_PAYLOAD:      o.stat_value = payload_sum;
			STAT_PADDING:      o.stat_value = padding_sum;
			STAT_CLAIMS:       o.stat_value = grants_sum;
			STAT_LAST_CLAIMED: o.stat_value = last_frame[0];
			STAT_LAST_PAYLOAD: o.stat_value = last_frame[1];
			STAT_LAST_PADDING: o.stat_value = last_frame[2];
			STAT_LAST_CLAIMS:  o.stat_value = last_frame[3];
			STAT_PEAK:         o.stat_value = peak;
			STAT_OUTSTANDING:  o.stat_value = outstanding;
			STAT_OVERFLOWS:    o.stat_value = STAT_W'(full_refusals);
			STAT_FAIL_SIZE:    o.stat_value = fail_rec[0];
			STAT_FAIL_ALIGN:   o.stat_value = fail_rec[1];
			STAT_FAIL_CLAIMED: o.stat_value = fail_rec[2];
			default:           o.stat_value = '0;
			endcase
		end
		endcase
		return o;
	endfunction

	// Idle lengths: mostly none, often short, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic aba_req_t req_of(logic [FUNC_W-1:0] f, logic [REQ_W-1:0] size,
			logic [ALOG_W-1:0] alog, logic [ADDR_W-1:0] addr, logic [SIDX_W-1:0] sidx);
		aba_req_t r;
		r.func = f;
		r.request_size = size;
		r.align_log2 = alog;
		r.release_address = addr;
		r.stat_index = sidx;
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] any_address();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// Allocation sizes: mostly small, some page sized, a few up to the whole arena.
	function automatic logic [REQ_W-1:0] pick_size();
		int unsigned r;
		logic [31:0] lim;
		r = $urandom_range(0, 99);
		lim = (64'(cap_reg) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cap_reg[31:0];
		if (r < 45)
			return $urandom_range(0, 64);
		if (r < 80)
			return $urandom_range(65, 4096);
		if (r < 95)
			return $urandom_range(0, lim);
		return $urandom;
	endfunction

	// Exponents past the supported maximum appear now and then to exercise clamping.
	function automatic logic [ALOG_W-1:0] pick_align();
		if ($urandom_range(0, 99) < 85)
			return ALOG_W'($urandom_range(0, MAX_ALIGN_LOG2_DEF));
		return ALOG_W'($urandom_range(MAX_ALIGN_LOG2_DEF + 1, 15));
	endfunction

	// Release addresses: mostly inside the arena, otherwise just outside or anywhere.
	function automatic logic [ADDR_W-1:0] pick_release();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 85 && cap_reg != '0)
			return ADDR_W'((64'(base_reg) + 64'($urandom_range(0, 32'(cap_reg - 1'b1))))
				& ADDR_MASK);
		if (r < 90)
			return base_reg - 1'b1;
		if (r < 95)
			return ADDR_W'((64'(base_reg) + 64'(cap_reg)) & ADDR_MASK);
		return any_address();
	endfunction

	function automatic logic [63:0] pick_capacity();
		case ($urandom_range(0, 6))
		0: return MIB;
		1: return 64'd4096;
		2: return 64'd64;
		3: return 64'd1;
		4: return 64'h1_0000_0000;
		5: return 64'($urandom_range(1, 32'h0100_0000));
		default: return 64'($urandom);
		endcase
	endfunction

	function automatic logic [63:0] pick_base();
		case ($urandom_range(0, 4))
		0: return 64'd0;
		1: return ADDR_MASK;
		2: return 64'(any_address()) & ~64'd63;
		3: return 64'(any_address());
		default: return ADDR_MASK - MIB + 64'd1;
		endcase
	endfunction

	// Driver: offers queued requests with random gaps between them. A request stays
	// on the bus unchanged until it is taken, and it is predicted at the edge that
	// takes it.
	always @(posedge clk or negedge arst_n) begin : driver
		int unsigned gap_left;
		logic        next_valid;
		if (!arst_n) begin
			req_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (req_valid && !req_stall)
				predicted_rsps.push_back(arena_apply(req_data));
			if (!req_valid || !req_stall) begin
				next_valid = 1'b0;
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_requests.size() != 0) begin
					req_data <= pending_requests.pop_front();
					next_valid = 1'b1;
					gap_left = steady ? 0 : pick_gap();
				end
				req_valid <= next_valid;
			end
		end
	end

	task automatic check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// Monitor: stalls the response side at random, and for one long stretch whenever
	// the sequencing block asks for it, and checks every response taken against the
	// oldest prediction.
	always @(posedge clk or negedge arst_n) begin : monitor
		int unsigned stall_left;
		int unsigned hold_left;
		bit          pressure_seen;
		aba_rsp_t    want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left = 0;
			hold_left = 0;
			pressure_seen = 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (predicted_rsps.size() == 0) begin
					$display("%0t: unexpected response: expected none, actual %p",
						$time, rsp_data);
					mismatches++;
				end else begin
					want = predicted_rsps.pop_front();
					check_field("status", 64'(want.status), 64'(rsp_data.status));
					check_field("grant_address", 64'(want.grant_address),
						64'(rsp_data.grant_address));
					check_field("stat_value", 64'(want.stat_value), 64'(rsp_data.stat_value));
				end
			end
			if (pressure_req != pressure_seen) begin
				pressure_seen = pressure_req;
				hold_left = LONG_HOLD;
			end
			if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
			rsp_stall <= (stall_left != 0) || (hold_left != 0);
			if (stall_left != 0)
				stall_left--;
			if (hold_left != 0)
				hold_left--;
		end
	end

	// Counts cycles in which nothing moves on any port.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_wr)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("FAILURE");
		$finish;
	end

	// Waits until every queued request has been taken and answered, then lets the
	// pipeline run empty before anything else happens.
	task automatic settle();
		while (pending_requests.size() != 0 || predicted_rsps.size() != 0 || req_valid)
			@(negedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Writes both arena registers while the block is idle.
	task automatic program_arena(input logic [63:0] capacity, input logic [63:0] base);
		@(posedge clk);
		cfg_wr <= 1'b1;
		cfg_idx <= REG_CAPACITY;
		cfg_wdata <= capacity[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_idx <= REG_BASE;
		cfg_wdata <= base[CFG_DATA_W-1:0];
		cap_reg = capacity[CAP_W-1:0];
		@(posedge clk);
		cfg_wr <= 1'b0;
		base_reg = base[ADDR_W-1:0];
		@(negedge clk);
	endtask

	// One frame as software would issue it: a few allocations with the odd statistic
	// read, roughly as many releases, then a frame reset. Sometimes a release is
	// missing, so the reset is refused, or one too many is sent, which drains any
	// leftover.
	task automatic queue_frame();
		int unsigned n, k;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			pending_requests.push_back(req_of(FUNC_ALLOC, pick_size(), pick_align(),
				any_address(), SIDX_W'($urandom)));
			if ($urandom_range(0, 4) == 0)
				pending_requests.push_back(req_of(FUNC_READ_STAT, REQ_W'($urandom),
					ALOG_W'($urandom), any_address(), SIDX_W'($urandom)));
		end
		case ($urandom_range(0, 9))
		0: k = n - 1;
		1, 2: k = n + 1;
		default: k = n;
		endcase
		for (int i = 0; i < k; i++)
			pending_requests.push_back(req_of(FUNC_RELEASE, REQ_W'($urandom),
				ALOG_W'($urandom), pick_release(), SIDX_W'($urandom)));
		if ($urandom_range(0, 3) == 0)
			pending_requests.push_back(req_of(FUNC_READ_STAT, REQ_W'($urandom),
				ALOG_W'($urandom), any_address(), SIDX_W'($urandom)));
		pending_requests.push_back(req_of(FUNC_FRAME_RESET, REQ_W'($urandom),
			ALOG_W'($urandom), any_address(), SIDX_W'($urandom)));
	endtask

	// Mostly well-formed frames; the rest are requests with every field random.
	task automatic queue_random_phase(input int unsigned count);
		int unsigned queued;
		queued = 0;
		while (queued < count) begin
			if ($urandom_range(0, 99) < 85) begin
				k_frame: begin
					int unsigned before_sz;
					before_sz = pending_requests.size();
					queue_frame();
					queued += pending_requests.size() - before_sz;
				end
			end else begin
				pending_requests.push_back(req_of(FUNC_W'($urandom), REQ_W'($urandom),
					ALOG_W'($urandom), any_address(), SIDX_W'($urandom)));
				queued++;
			end
		end
	endtask

	initial begin : sequencer
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: 1 MiB arena at address zero. Zero-byte claim, page alignment,
		// a clamped alignment exponent, a request that cannot fit, the failure record,
		// releases outside the arena and with nothing outstanding, a refused and an
		// accepted frame reset, the last-frame values, undefined statistics, and a
		// claim that exactly fills the arena.
		pending_requests.push_back(req_of(FUNC_ALLOC, 32'd0, 4'd0, '0, '0));
		pending_requests.push_back(req_of(FUNC_ALLOC, 32'd1, 4'd12, '0, '0));
		pending_requests.push_back(req_of(FUNC_ALLOC, 32'd100, 4'd15, '0, '0));
		pending_requests.push_back(req_of(FUNC_ALLOC, 32'hFFFF_FFFF, 4'd0, '0, '0));
		pending_requests.push_back(req_of(FUNC_READ_STAT, '0, '0, '0, STAT_FAIL_SIZE));
		pending_requests.push_back(req_of(FUNC_READ_STAT, '0, '0, '0, STAT_FAIL_ALIGN));
		pending_requests.push_back(req_of(FUNC_READ_STAT, '0, '0, '0, STAT_FAIL_CLAIMED));
		pending_requests.push_back(req_of(FUNC_READ_STAT, '0, '0, '0, STAT_OVERFLOWS));
		pending_requests.push_back(req_of(FUNC_RELEASE, '0, '0, '1, '0));
		pending_requests.push_back(req_of(FUNC_FRAME_RESET, '0, '0, '0, '0));
		pending_requests.push_back(req_of(FUNC_RELEASE, '0, '0, 48'd0, '0));
		pending_requests.push_back(req_of(FUNC_RELEASE, '0, '0, 48'd4096, '0));
		pending_requests.push_back(req_of(FUNC_RELEASE, '0, '0, 48'd8192, '0));
		pending_requests.push_back(req_of(FUNC_RELEASE, '0, '0, 48'd0, '0));
		pending_requests.push_back(req_of(FUNC_FRAME_RESET, '1, '1, '1, '1));
		pending_requests.push_back(req_of(FUNC_READ_STAT, '0, '0, '0, STAT_LAST_CLAIMED));
		pending_requests.push_back(req_of(FUNC_READ_STAT, '0, '0, '0, STAT_LAST_PAYLOAD));
		pending_requests.push_back(req_of(FUNC_READ_STAT, '0, '0, '0, STAT_LAST_PADDING));
		pending_requests.push_back(req_of(FUNC_READ_STAT, '0, '0, '0, STAT_LAST_CLAIMS));
		pending_requests.push_back(req_of(FUNC_READ_STAT, '0, '0, '0, STAT_PEAK));
		pending_requests.push_back(req_of(FUNC_READ_STAT, '0, '0, '0, STAT_UNUSED_LO));
		pending_requests.push_back(req_of(FUNC_READ_STAT, '1, '1, '1, STAT_UNUSED_HI));
		pending_requests.push_back(req_of(FUNC_ALLOC, 32'(MIB), 4'd0, '0, '0));
		pending_requests.push_back(req_of(FUNC_ALLOC, 32'd0, 4'd0, '0, '0));
		pending_requests.push_back(req_of(FUNC_READ_STAT, '0, '0, '0, STAT_CLAIMED));
		pending_requests.push_back(req_of(FUNC_READ_STAT, '0, '0, '0, STAT_OUTSTANDING));

		// The arena shrinks below what is already claimed: allocation must fail until
		// the frame is released and reset.
		settle();
		program_arena(64'd4096, 64'd0);
		pending_requests.push_back(req_of(FUNC_ALLOC, 32'd16, 4'd4, '0, '0));
		pending_requests.push_back(req_of(FUNC_RELEASE, '0, '0, 48'd0, '0));
		pending_requests.push_back(req_of(FUNC_FRAME_RESET, '0, '0, '0, '0));
		pending_requests.push_back(req_of(FUNC_ALLOC, 32'd4096, 4'd0, '0, '0));
		pending_requests.push_back(req_of(FUNC_ALLOC, 32'd0, 4'd0, '0, '0));
		pending_requests.push_back(req_of(FUNC_RELEASE, '0, '0, 48'd4095, '0));
		pending_requests.push_back(req_of(FUNC_RELEASE, '0, '0, 48'd4096, '0));

		// Zero capacity at the top of the address space: nothing fits, nothing is owned.
		settle();
		program_arena(64'd0, ADDR_MASK);
		pending_requests.push_back(req_of(FUNC_ALLOC, 32'd0, 4'd0, '0, '0));
		pending_requests.push_back(req_of(FUNC_RELEASE, '0, '0, '1, '0));
		pending_requests.push_back(req_of(FUNC_FRAME_RESET, '0, '0, '0, '0));
		pending_requests.push_back(req_of(FUNC_READ_STAT, '0, '0, '0, STAT_FAIL_CLAIMED));

		// A 4 GiB arena just below the address limit: the aligned address wraps to
		// zero, then a claim fills the rest of the 4 GiB arena exactly.
		settle();
		program_arena(64'h1_0000_0000, ADDR_MASK - 64'd15);
		pending_requests.push_back(req_of(FUNC_ALLOC, 32'd0, 4'd12, '0, '0));
		pending_requests.push_back(req_of(FUNC_ALLOC, 32'hFFFF_FFFF, 4'd0, '0, '0));
		pending_requests.push_back(req_of(FUNC_ALLOC, 32'hFFFF_FFEF, 4'd0, '0, '0));
		pending_requests.push_back(req_of(FUNC_READ_STAT, '0, '0, '0, STAT_CLAIMED));
		pending_requests.push_back(req_of(FUNC_RELEASE, '0, '0, ADDR_W'(ADDR_MASK - 15), '0));
		pending_requests.push_back(req_of(FUNC_RELEASE, '0, '0, '1, '0));
		pending_requests.push_back(req_of(FUNC_FRAME_RESET, '0, '0, '0, '0));
		pending_requests.push_back(req_of(FUNC_READ_STAT, '0, '0, '0, STAT_PAYLOAD));
		pending_requests.push_back(req_of(FUNC_READ_STAT, '0, '0, '0, STAT_PEAK));

		// Random phases, each under freshly drawn arena settings. Some run without any
		// idling; two of those also hold the response side off long enough for the
		// block to fill and stall its input.
		for (int p = 0; p < 10; p++) begin
			settle();
			program_arena(pick_capacity(), pick_base());
			steady = (p == 2 || p == 3 || p == 7);
			if (p == 3 || p == 7)
				pressure_req = ~pressure_req;
			queue_random_phase(90);
		end

		settle();
		repeat (5) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* aligned_bump_allocator_top.f */
design/aba_pkg.sv
design/aba_cfg_regs.sv
design/aba_engine.sv
design/aligned_bump_allocator_top.sv
tb/sv/tb_aligned_bump_allocator_top.sv
